[rtl/msps_pkg.sv]
package msps_pkg;

    localparam int SERVO_COUNT_DEFAULT = 8;

    // Width of the channel pointer; it also holds the count (gap marker).
    localparam int CHAN_W = 4;
    localparam int PIN_W  = 8;

    localparam int MIN_W    = 12;
    localparam int FRAME_W  = 15;
    localparam int ANGLE_W  = 8;
    localparam int TICK_W   = 13;
    localparam int TIMER_W  = 16;
    localparam int PROD_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [ANGLE_W-1:0] ANGLE_CAP      = 8'd180;
    localparam logic [TIMER_W-1:0] FULL_GAP_TICKS = 16'd1000;

    // floor(p / 180) = floor(floor(p / 4) / 45); the /45 is a multiply by
    // ceil(2^24 / 45) and a shift, exact for every p below 2^20.
    localparam int DIV_IN_W   = PROD_W - 2;
    localparam int RECIP_W    = 19;
    localparam int RECIP_SH   = 24;
    localparam logic [RECIP_W-1:0] RECIP_45 = 19'd372828;
    localparam int QUOT_W     = DIV_IN_W + RECIP_W;

    localparam logic [MIN_W-1:0]   MIN_PULSE_RESET     = 12'd1000;
    localparam logic [MIN_W-1:0]   MAX_PULSE_RESET     = 12'd2000;
    localparam logic [FRAME_W-1:0] FRAME_RESET         = 15'd20000;
    localparam logic [ANGLE_W-1:0] DEFAULT_ANGLE_RESET = 8'd0;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_SET_ANGLE = 2'd1,
        KIND_START     = 2'd2,
        KIND_UNUSED    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE     = 3'd0,
        REG_MAX_PULSE     = 3'd1,
        REG_FRAME         = 3'd2,
        REG_DEFAULT_ANGLE = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        kind_t        kind;
        logic [3:0]   servo_channel;
        logic [7:0]   angle_deg;
    } msps_in_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_levels;
        logic [CHAN_W-1:0] active_channel;
        logic              gap_active;
        logic              compare_event;
    } msps_out_t;

endpackage

[rtl/multichannel_servo_pulse_sequencer_core.sv]
// A word accepted on s_ is registered at each stage and in the output register before it shows on m_.
// Throughput: one word per clock, sustained; every stage moves on as soon as the
// stage after it is free, so bubbles close up and only m_ready backpressure stalls.
// Reset (aresetn low at a clock edge): drop all words in flight, stop the sequencer
// (not running, channel 0, no gap) and load the configuration registers with defaults.
module multichannel_servo_pulse_sequencer_core #(
    parameter int SERVO_COUNT = msps_pkg::SERVO_COUNT_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  msps_pkg::msps_in_t                   s_data,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output msps_pkg::msps_out_t                  m_data,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import msps_pkg::*;

    // Table index width; at least one bit so a single-channel build still works.
    localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(SERVO_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers. Write them only while the block is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [MIN_W-1:0]   min_pulse_reg;
    logic [MIN_W-1:0]   max_pulse_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [ANGLE_W-1:0] default_angle_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg     <= MIN_PULSE_RESET;
            max_pulse_reg     <= MAX_PULSE_RESET;
            frame_reg         <= FRAME_RESET;
            default_angle_reg <= DEFAULT_ANGLE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_PULSE:     min_pulse_reg     <= cfg_data[MIN_W-1:0];
                REG_MAX_PULSE:     max_pulse_reg     <= cfg_data[MIN_W-1:0];
                REG_FRAME:         frame_reg         <= cfg_data[FRAME_W-1:0];
                REG_DEFAULT_ANGLE: default_angle_reg <= cfg_data[ANGLE_W-1:0];
                default: begin
                    // unknown index: drop the word
                end
            endcase
        end
    end

    // Span of the pulse range; a maximum below the minimum pins every angle to min.
    logic [MIN_W-1:0] span;
    assign span = (max_pulse_reg > min_pulse_reg) ? (max_pulse_reg - min_pulse_reg)
                                                  : '0;

    // ------------------------------------------------------------------
    // Handshake chain. A stage loads when it is empty or its word moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic out_ready, s3_ready, s2_ready, s1_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg  || out_ready;
    assign s2_ready  = !s2_valid_reg  || s3_ready;
    assign s1_ready  = !s1_valid_reg  || s2_ready;
    assign s_ready   = s1_ready;

    logic s1_load, s2_load, s3_load, out_load;
    assign s1_load  = s_valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s3_load  = s2_valid_reg && s3_ready;
    assign out_load = s3_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready)  s1_valid_reg  <= s_valid;
            if (s2_ready)  s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)  s3_valid_reg  <= s2_valid_reg;
            if (out_ready) out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the angle (the default one for start) and cap it at 180.
    // ------------------------------------------------------------------
    kind_t              s1_kind_reg;
    logic [3:0]         s1_chan_reg;
    logic [ANGLE_W-1:0] s1_angle_reg;
    logic [ANGLE_W-1:0] angle_src;

    assign angle_src = (s_data.kind == KIND_START) ? default_angle_reg : s_data.angle_deg;

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_kind_reg  <= s_data.kind;
            s1_chan_reg  <= s_data.servo_channel;
            s1_angle_reg <= (angle_src > ANGLE_CAP) ? ANGLE_CAP : angle_src;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: span * angle.
    // ------------------------------------------------------------------
    kind_t             s2_kind_reg;
    logic [3:0]        s2_chan_reg;
    logic [PROD_W-1:0] s2_prod_reg;

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_kind_reg <= s1_kind_reg;
            s2_chan_reg <= s1_chan_reg;
            s2_prod_reg <= PROD_W'(span * s1_angle_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 180 through the reciprocal, add min, convert to ticks.
    // ------------------------------------------------------------------
    logic [QUOT_W-1:0]  quot_full;
    logic [MIN_W-1:0]   quot;
    logic [MIN_W:0]     pulse_us;
    kind_t              s3_kind_reg;
    logic [3:0]         s3_chan_reg;
    logic [TICK_W-1:0]  s3_ticks_reg;

    assign quot_full = s2_prod_reg[PROD_W-1:2] * RECIP_45;
    assign quot      = quot_full[RECIP_SH +: MIN_W];
    assign pulse_us  = {1'b0, min_pulse_reg} + {1'b0, quot};

    always_ff @(posedge aclk) begin
        if (s3_load) begin
            s3_kind_reg  <= s2_kind_reg;
            s3_chan_reg  <= s2_chan_reg;
            // two ticks per microsecond, kept to the table width
            s3_ticks_reg <= {pulse_us[TICK_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: advance the frame state as a word leaves stage 3.
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]  table_reg [SERVO_COUNT];
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic               gap_reg, gap_next;
    logic [TICK_W-1:0]  active_reg, active_next;
    logic [TIMER_W-1:0] used_reg, used_next;
    logic [TIMER_W-1:0] remain_reg, remain_next;
    logic               running_reg, running_next;
    logic               event_next;

    logic [TIMER_W-1:0] remain_dec;
    logic [TIMER_W-1:0] used_sum;
    logic [TIMER_W-1:0] frame_ticks;
    logic [CHAN_W-1:0]  chan_inc;
    logic [TICK_W-1:0]  next_pulse;

    assign remain_dec  = remain_reg - 1'b1;
    assign used_sum    = used_reg + TIMER_W'(active_reg);
    assign frame_ticks = {frame_reg, 1'b0};
    assign chan_inc    = chan_reg + 1'b1;
    assign next_pulse  = table_reg[chan_inc[IDX_W-1:0]];

    always_comb begin
        chan_next    = chan_reg;
        gap_next     = gap_reg;
        active_next  = active_reg;
        used_next    = used_reg;
        remain_next  = remain_reg;
        running_next = running_reg;
        event_next   = 1'b0;

        case (s3_kind_reg)
            KIND_TICK: begin
                if (running_reg) begin
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        event_next = 1'b1;
                        if (!gap_reg) begin
                            // drop this pin, raise the next or open the gap
                            used_next = used_sum;
                            chan_next = chan_inc;
                            if (chan_inc < LAST_CHAN) begin
                                active_next = next_pulse;
                                remain_next = TIMER_W'(next_pulse);
                            end else begin
                                gap_next    = 1'b1;
                                remain_next = (used_sum < frame_ticks)
                                            ? (frame_ticks - used_sum) : FULL_GAP_TICKS;
                            end
                        end else begin
                            // gap over: start the next frame at channel 0
                            chan_next   = '0;
                            gap_next    = 1'b0;
                            used_next   = '0;
                            active_next = table_reg[0];
                            remain_next = TIMER_W'(table_reg[0]);
                        end
                    end
                end
            end
            KIND_START: begin
                chan_next    = '0;
                gap_next     = 1'b0;
                used_next    = '0;
                active_next  = s3_ticks_reg;
                remain_next  = TIMER_W'(s3_ticks_reg);
                running_next = 1'b1;
            end
            default: begin
                // set angle touches only the table; the unused kind does nothing
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg    <= '0;
            gap_reg     <= 1'b0;
            active_reg  <= '0;
            used_reg    <= '0;
            remain_reg  <= '0;
            running_reg <= 1'b0;
        end else if (out_load) begin
            chan_reg    <= chan_next;
            gap_reg     <= gap_next;
            active_reg  <= active_next;
            used_reg    <= used_next;
            remain_reg  <= remain_next;
            running_reg <= running_next;
        end
    end

    // Pulse table: start fills every entry, set angle writes one in-range entry.
    // A write while running takes effect the next time that channel rises.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < SERVO_COUNT; i++) begin
                if (s3_kind_reg == KIND_START) begin
                    table_reg[i] <= s3_ticks_reg;
                end else if (s3_kind_reg == KIND_SET_ANGLE
                             && s3_chan_reg == 4'(i)) begin
                    table_reg[i] <= s3_ticks_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: the state after the word, plus the expiry flag.
    // ------------------------------------------------------------------
    msps_out_t out_reg;
    logic [PIN_W-1:0] pins_next;

    assign pins_next = (running_next && !gap_next && chan_next < CHAN_W'(PIN_W))
                     ? (PIN_W'(1) << chan_next) : '0;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.pin_levels     <= pins_next;
            out_reg.active_channel <= chan_next;
            out_reg.gap_active     <= gap_next;
            out_reg.compare_event  <= event_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_gap_at_count: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_reg |-> chan_reg == LAST_CHAN)
        else $error("gap runs with channel pointer not at count");

    a_chan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg && !gap_reg) |-> chan_reg < LAST_CHAN)
        else $error("pulsing channel out of range");

    a_idle_home: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (chan_reg == '0 && !gap_reg))
        else $error("idle sequencer left its home position");

    a_event_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && event_next) |-> (s3_kind_reg == KIND_TICK && running_reg))
        else $error("expiry flagged on a word that is not a running tick");

    a_pins_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($onehot0(out_reg.pin_levels)
                           && !(out_reg.gap_active && out_reg.pin_levels != '0)))
        else $error("more than one pin high, or a pin high during the gap");

endmodule

[test/msps_checker.sv]
module msps_checker
    import msps_pkg::*;
#(
    parameter int SERVO_COUNT = SERVO_COUNT_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  msps_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  msps_out_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    words_pending
);

    localparam int TICKS_PER_US = 2;
    localparam int SHOWN_FAILURES = 10;

    // Shadow copy of the configuration registers.
    logic [MIN_W-1:0]   min_us;
    logic [MIN_W-1:0]   max_us;
    logic [FRAME_W-1:0] frame_us;
    logic [ANGLE_W-1:0] start_angle;

    // Shadow copy of the sequencer state.
    logic [TICK_W-1:0]  pulse_tbl [PIN_W];
    logic [CHAN_W-1:0]  chan;
    logic               in_gap;
    logic [TICK_W-1:0]  cur_pulse;
    logic [TIMER_W-1:0] used_ticks;
    logic [TIMER_W-1:0] remaining;
    logic               running;

    msps_out_t pin_state_q[$];
    int        fail_total;

    function automatic logic [TICK_W-1:0] angle_ticks(input logic [ANGLE_W-1:0] angle);
        int unsigned capped;
        int unsigned span;
        int unsigned pulse;
        capped = (angle > ANGLE_CAP) ? int'(ANGLE_CAP) : int'(angle);
        span   = (max_us > min_us) ? int'(max_us) - int'(min_us) : 0;
        pulse  = int'(min_us) + (span * capped) / int'(ANGLE_CAP);
        return TICK_W'(pulse * TICKS_PER_US);
    endfunction

    function automatic void open_frame();
        chan       = '0;
        in_gap     = 1'b0;
        used_ticks = '0;
        cur_pulse  = pulse_tbl[0];
        remaining  = TIMER_W'(pulse_tbl[0]);
    endfunction

    // Countdown hit zero: hand over to the next pin, the gap, or a new frame.
    function automatic void advance_pin();
        int unsigned frame_ticks;
        if (!in_gap) begin
            used_ticks = used_ticks + TIMER_W'(cur_pulse);
            chan = chan + 1'b1;
            if (chan < SERVO_COUNT) begin
                cur_pulse = pulse_tbl[chan[2:0]];
                remaining = TIMER_W'(cur_pulse);
            end else begin
                frame_ticks = int'(frame_us) * TICKS_PER_US;
                in_gap = 1'b1;
                if (used_ticks < frame_ticks) begin
                    remaining = TIMER_W'(frame_ticks - used_ticks);
                end else begin
                    remaining = FULL_GAP_TICKS;
                end
            end
        end else begin
            open_frame();
        end
    endfunction

    function automatic msps_out_t predict_pins(input msps_in_t w);
        msps_out_t         r;
        logic [TICK_W-1:0] t;
        int                i;
        r = '0;
        case (w.kind)
            KIND_TICK: begin
                if (running) begin
                    remaining = remaining - 1'b1;
                    if (remaining == '0) begin
                        r.compare_event = 1'b1;
                        advance_pin();
                    end
                end
            end
            KIND_SET_ANGLE: begin
                if (w.servo_channel < SERVO_COUNT) begin
                    pulse_tbl[w.servo_channel[2:0]] = angle_ticks(w.angle_deg);
                end
            end
            KIND_START: begin
                t = angle_ticks(start_angle);
                for (i = 0; i < PIN_W; i++) begin
                    pulse_tbl[i] = (i < SERVO_COUNT) ? t : '0;
                end
                open_frame();
                running = 1'b1;
            end
            default: ;
        endcase
        if (running && !in_gap && chan < PIN_W) begin
            r.pin_levels = PIN_W'(1) << chan;
        end
        r.active_channel = chan;
        r.gap_active     = in_gap;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_total++;
        if (fail_total <= SHOWN_FAILURES) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    always @(posedge aclk) begin
        msps_out_t want;
        int        i;
        if (!aresetn) begin
            min_us      = MIN_PULSE_RESET;
            max_us      = MAX_PULSE_RESET;
            frame_us    = FRAME_RESET;
            start_angle = DEFAULT_ANGLE_RESET;
            for (i = 0; i < PIN_W; i++) begin
                pulse_tbl[i] = '0;
            end
            chan       = '0;
            in_gap     = 1'b0;
            cur_pulse  = '0;
            used_ticks = '0;
            remaining  = '0;
            running    = 1'b0;
            pin_state_q.delete();
            fail_total = 0;
        end else begin
            // Retire first: a result never belongs to a word taken at the same edge.
            if (m_valid && m_ready) begin
                if (pin_state_q.size() == 0) begin
                    note_failure($sformatf("unexpected result word %h", m_data));
                end else begin
                    want = pin_state_q.pop_front();
                    if (want.pin_levels !== m_data.pin_levels
                            || want.active_channel !== m_data.active_channel
                            || want.gap_active !== m_data.gap_active
                            || want.compare_event !== m_data.compare_event) begin
                        note_failure($sformatf(
                            "mismatch: pins %h/%h chan %0d/%0d gap %b/%b event %b/%b (exp/act)",
                            want.pin_levels, m_data.pin_levels,
                            want.active_channel, m_data.active_channel,
                            want.gap_active, m_data.gap_active,
                            want.compare_event, m_data.compare_event));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MIN_PULSE:     min_us      = cfg_data[MIN_W-1:0];
                    REG_MAX_PULSE:     max_us      = cfg_data[MIN_W-1:0];
                    REG_FRAME:         frame_us    = cfg_data[FRAME_W-1:0];
                    REG_DEFAULT_ANGLE: start_angle = cfg_data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pin_state_q.push_back(predict_pins(s_data));
            end
        end
        error_count   <= fail_total;
        words_pending <= pin_state_q.size();
    end

endmodule

[test/testbench.sv]
module testbench;
    import msps_pkg::*;

    localparam int CLK_HIGH        = 6;
    localparam int CLK_LOW         = 6;
    localparam int RESET_CYCLES    = 4;
    // Longest run of cycles with no word moving on any channel before giving up.
    localparam int STALL_LIMIT     = 4000;
    // Cycles to let pass once nothing is expected; well above the pipeline latency.
    localparam int DRAIN_PAUSE     = 8;
    // Length of the deliberate receiver hold-off that backs the pipeline up.
    localparam int HOLD_CYCLES     = 300;
    // Ticks with a zero-length channel 0: it must keep pulsing, as the timer wraps.
    localparam int ZERO_LOAD_TICKS = 100;
    localparam int PHASE_WORDS     = 120;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    msps_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    msps_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pace_t pace         = PACE_FREE;
    logic  hold_request = 1'b0;
    logic  hold_taken   = 1'b0;
    int    hold_left    = 0;
    int    quiet_cycles = 0;
    int    error_count;
    int    words_pending;

    always begin
        #CLK_LOW  aclk = 1'b1;
        #CLK_HIGH aclk = 1'b0;
    end

    multichannel_servo_pulse_sequencer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msps_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    // Result side: hold off once for a long stretch when asked, otherwise
    // stall at random according to the current pacing.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            case (pace)
                PACE_RECEIVER: m_ready <= ($urandom_range(99) >= 47);
                PACE_BOTH:     m_ready <= ($urandom_range(99) >= 14);
                default:       m_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: count cycles in which no word moves anywhere.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic msps_in_t make_word(input kind_t k, input int unsigned chan,
                                           input int unsigned angle);
        msps_in_t w;
        w.kind          = k;
        w.servo_channel = 4'(chan);
        w.angle_deg     = 8'(angle);
        return w;
    endfunction

    // Mostly ticks so the sequence moves; some angle updates (mostly in range),
    // the odd restart and the odd unused kind.
    function automatic msps_in_t random_word(input int tick_pct);
        msps_in_t w;
        int       roll;
        w.servo_channel = ($urandom_range(99) < 80) ? 4'($urandom_range(7))
                                                    : 4'($urandom_range(15));
        w.angle_deg = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < tick_pct) begin
            w.kind = KIND_TICK;
        end else if (roll < 97) begin
            w.kind = KIND_SET_ANGLE;
        end else if (roll < 99) begin
            w.kind = KIND_START;
        end else begin
            w.kind = KIND_UNUSED;
        end
        return w;
    endfunction

    // Offer one word, idling first as the pacing says; return once it is taken.
    task automatic send_word(input msps_in_t w);
        int idle_pct;
        case (pace)
            PACE_SENDER: idle_pct = 47;
            PACE_BOTH:   idle_pct = 14;
            default:     idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Drop valid, wait until every expected result word is back, then let the
    // pipeline settle.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic apply_settings(input int unsigned min_v, input int unsigned max_v,
                                  input int unsigned frame_v, input int unsigned angle_v);
        settle();
        write_reg(REG_MIN_PULSE, min_v);
        write_reg(REG_MAX_PULSE, max_v);
        write_reg(REG_FRAME, frame_v);
        write_reg(REG_DEFAULT_ANGLE, angle_v);
        cfg_valid <= 1'b0;
    endtask

    // One configuration, a start, then a stream of random words.
    task automatic run_phase(input int unsigned min_v, input int unsigned max_v,
                             input int unsigned frame_v, input int unsigned angle_v,
                             input pace_t p, input int count, input int tick_pct,
                             input logic squeeze);
        apply_settings(min_v, max_v, frame_v, angle_v);
        pace <= p;
        send_word(make_word(KIND_START, $urandom_range(15), $urandom_range(255)));
        if (squeeze) begin
            hold_request <= 1'b1;
        end
        repeat (count) send_word(random_word(tick_pct));
    endtask

    initial begin
        int c;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at the reset configuration.
        // Before the first start ticks move nothing.
        send_word(make_word(KIND_TICK, 15, 255));
        send_word(make_word(KIND_TICK, 0, 0));
        send_word(make_word(KIND_UNUSED, 15, 255));
        // Angle above the cap, then two channels past the last servo.
        send_word(make_word(KIND_SET_ANGLE, 7, 255));
        send_word(make_word(KIND_SET_ANGLE, 8, 90));
        send_word(make_word(KIND_SET_ANGLE, 15, 0));
        send_word(make_word(KIND_START, 0, 0));
        repeat (3) send_word(make_word(KIND_TICK, 0, 0));
        // Table writes while running, then restart in mid-frame.
        send_word(make_word(KIND_SET_ANGLE, 0, 0));
        send_word(make_word(KIND_SET_ANGLE, 3, 180));
        send_word(make_word(KIND_START, 9, 45));
        send_word(make_word(KIND_UNUSED, 0, 255));
        send_word(make_word(KIND_TICK, 0, 0));

        // Short pulses and frames so that pins, gaps and restarts all turn over.
        run_phase(1, 4, 30, 90, PACE_FREE, PHASE_WORDS, 80, 1'b1);
        // Maximum below minimum: every angle lands on the minimum.
        run_phase(2, 1, 40, 255, PACE_SENDER, PHASE_WORDS, 80, 1'b0);
        run_phase(3, 9, 60, 45, PACE_RECEIVER, PHASE_WORDS, 80, 1'b0);
        run_phase(1, 2, 25, 180, PACE_BOTH, PHASE_WORDS, 80, 1'b0);
        // Frame shorter than the pulses: the gap falls back to the full length.
        run_phase(1, 3, 12, 120, PACE_FREE, PHASE_WORDS, 85, 1'b0);
        // Used ticks exactly equal to the frame; run well into the full gap.
        run_phase(1, 1, 8, 0, PACE_BOTH, 200, 100, 1'b0);

        // Zero load: channel 0 loads 0 and keeps pulsing, since its countdown
        // wraps the timer; the other channels get short pulses.
        apply_settings(0, 4095, 0, 0);
        pace <= PACE_FREE;
        send_word(make_word(KIND_START, 0, 0));
        for (c = 1; c < 8; c++) begin
            send_word(make_word(KIND_SET_ANGLE, c, 1));
        end
        repeat (ZERO_LOAD_TICKS) send_word(make_word(KIND_TICK, 0, 0));

        // Upper register extremes with the maximum at zero.
        run_phase(4095, 0, 32767, 255, PACE_SENDER, 40, 80, 1'b0);

        settle();
        if (error_count == 0 && words_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/msps_pkg.sv
rtl/multichannel_servo_pulse_sequencer_core.sv
test/msps_checker.sv
test/testbench.sv
